/* hw/rtl/qvr_pkg.sv */
// Shared widths and the item type passed from the front end to the divider back end.
package qvr_pkg;

  localparam int QW = 16;           // quaternion component width
  localparam int VW = 32;           // vector component width
  localparam int NW = 33;           // norm width, n <= 2^32
  localparam int SW = 68;           // signed numerator width
  localparam int MW = 66;           // numerator magnitude width
  localparam int QB = 34;           // quotient bits produced by the divider
  localparam int RW = 33;           // divider remainder width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int IN_W = 4 * QW + 3 * VW;
  localparam int OUT_W = 3 * VW;

  typedef logic [MW-1:0] mag_t;

  typedef struct packed {
    logic            deg;
    logic [NW-1:0]   n;
    logic [2:0]      neg;
    mag_t [2:0]      mag;
  } item_t;

endpackage

/* hw/rtl/quaternion_vector_rotation.sv */
// Throughput: one item per cycle while the queue is not full; front end is 5 stages, back
// end is a 34-stage one-bit-per-stage divider plus a rounding/output register.
// A 4-entry queue lets the front end keep accepting while the back end is stalled.
// Synchronous active-high reset clears all valid and queue state; payload is not reset.
module quaternion_vector_rotation import qvr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // rot_x, rot_y, rot_z
  output logic [1:0]       m_axis_tuser    // degenerate, saturated
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  logic  deg;
  logic  sat;

  qvr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  qvr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  qvr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_deg   (deg),
    .out_sat   (sat)
  );

  assign m_axis_tuser = {sat, deg};

endmodule

/* hw/rtl/qvr_front.sv */
// Front end: products, norm, dot and cross terms, numerators and their magnitudes.
module qvr_front import qvr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output item_t           out_item
);

  logic [5:1] vld;
  logic en;

  logic signed [QW-1:0]   w1;
  logic signed [QW-1:0]   u1 [3];
  logic signed [VW-1:0]   v1 [3];
  logic signed [2*QW-1:0] sq1 [4];
  logic signed [47:0]     p1 [9];
  logic                   deg1;

  logic [NW-1:0]          n2;
  logic signed [NW-1:0]   a2;
  logic signed [49:0]     d2;
  logic signed [49:0]     c2 [3];
  logic signed [QW-1:0]   w2;
  logic signed [QW-1:0]   u2 [3];
  logic signed [VW-1:0]   v2 [3];
  logic                   deg2;

  logic signed [64:0]     pa3 [3];
  logic signed [65:0]     pu3 [3];
  logic signed [65:0]     pw3 [3];
  logic [NW-1:0]          n3;
  logic signed [VW-1:0]   v3 [3];
  logic                   deg3;

  logic signed [SW-1:0]   s4 [3];
  logic [NW-1:0]          n4;
  logic signed [VW-1:0]   v4 [3];
  logic                   deg4;

  logic signed [SW-1:0]   src [3];
  logic signed [SW-1:0]   sabs [3];

  assign en        = !vld[5] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:1], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src[i]  = deg4 ? SW'(v4[i]) : s4[i];
      sabs[i] = src[i][SW-1] ? -src[i] : src[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: capture and raw products
      w1    <= in_data[QW-1:0];
      u1[0] <= in_data[2*QW-1:QW];
      u1[1] <= in_data[3*QW-1:2*QW];
      u1[2] <= in_data[4*QW-1:3*QW];
      for (int i = 0; i < 3; i++) begin
        v1[i] <= in_data[4*QW+i*VW +: VW];
      end
      sq1[0] <= 32'($signed(in_data[QW-1:0])) * 32'($signed(in_data[QW-1:0]));
      sq1[1] <= 32'($signed(in_data[2*QW-1:QW])) * 32'($signed(in_data[2*QW-1:QW]));
      sq1[2] <= 32'($signed(in_data[3*QW-1:2*QW])) * 32'($signed(in_data[3*QW-1:2*QW]));
      sq1[3] <= 32'($signed(in_data[4*QW-1:3*QW])) * 32'($signed(in_data[4*QW-1:3*QW]));
      deg1   <= (in_data[4*QW-1:0] == '0);
      // stage 1 products of u and v for the dot and cross terms, indexed in p1
      p1[0] <= 48'($signed(in_data[2*QW-1:QW]))   * 48'($signed(in_data[4*QW +: VW]));
      p1[1] <= 48'($signed(in_data[3*QW-1:2*QW])) * 48'($signed(in_data[4*QW+VW +: VW]));
      p1[2] <= 48'($signed(in_data[4*QW-1:3*QW])) * 48'($signed(in_data[4*QW+2*VW +: VW]));
      p1[3] <= 48'($signed(in_data[3*QW-1:2*QW])) * 48'($signed(in_data[4*QW+2*VW +: VW]));
      p1[4] <= 48'($signed(in_data[4*QW-1:3*QW])) * 48'($signed(in_data[4*QW+VW +: VW]));
      p1[5] <= 48'($signed(in_data[4*QW-1:3*QW])) * 48'($signed(in_data[4*QW +: VW]));
      p1[6] <= 48'($signed(in_data[2*QW-1:QW]))   * 48'($signed(in_data[4*QW+2*VW +: VW]));
      p1[7] <= 48'($signed(in_data[2*QW-1:QW]))   * 48'($signed(in_data[4*QW+VW +: VW]));
      p1[8] <= 48'($signed(in_data[3*QW-1:2*QW])) * 48'($signed(in_data[4*QW +: VW]));

      // stage 2: norm, a, dot, cross
      n2 <= NW'($unsigned(sq1[0])) + NW'($unsigned(sq1[1]))
          + NW'($unsigned(sq1[2])) + NW'($unsigned(sq1[3]));
      a2 <= NW'(sq1[0]) - NW'(sq1[1]) - NW'(sq1[2]) - NW'(sq1[3]);
      d2 <= 50'(p1[0]) + 50'(p1[1]) + 50'(p1[2]);
      c2[0] <= 50'(p1[3]) - 50'(p1[4]);
      c2[1] <= 50'(p1[5]) - 50'(p1[6]);
      c2[2] <= 50'(p1[7]) - 50'(p1[8]);
      w2   <= w1;
      deg2 <= deg1;
      for (int i = 0; i < 3; i++) begin
        u2[i] <= u1[i];
        v2[i] <= v1[i];
      end

      // stage 3: second-level products
      for (int i = 0; i < 3; i++) begin
        pa3[i] <= 65'(a2) * 65'(v2[i]);
        pu3[i] <= 66'(u2[i]) * 66'(d2);
        pw3[i] <= 66'(w2) * 66'(c2[i]);
        v3[i]  <= v2[i];
      end
      n3   <= n2;
      deg3 <= deg2;

      // stage 4: numerators
      for (int i = 0; i < 3; i++) begin
        s4[i] <= SW'(pa3[i]) + (SW'(pu3[i]) <<< 1) + (SW'(pw3[i]) <<< 1);
        v4[i] <= v3[i];
      end
      n4   <= n3;
      deg4 <= deg3;

      // stage 5: sign and magnitude; identity passes v over a unit norm
      out_item.deg <= deg4;
      out_item.n   <= deg4 ? NW'(1) : n4;
      for (int i = 0; i < 3; i++) begin
        out_item.neg[i] <= src[i][SW-1];
        out_item.mag[i] <= sabs[i][MW-1:0];
      end
    end
  end

endmodule

/* hw/rtl/qvr_queue.sv */
// Small queue between the front end and the divider back end.
module qvr_queue import qvr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;
  logic push;
  logic pop;

  assign push_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

/* hw/rtl/qvr_back.sv */
// Back end: pipelined restoring division by the norm, rounding, saturation, output register.
module qvr_back import qvr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic             out_deg,
  output logic             out_sat
);

  logic [QB:0]    vld;
  logic           en;
  logic [RW-1:0]  rem  [QB+1][3];
  logic [QB-1:0]  low  [QB+1][3];
  logic [QB-1:0]  quo  [QB+1][3];
  logic [NW-1:0]  nrm  [QB+1];
  logic [2:0]     neg  [QB+1];
  logic           deg  [QB+1];

  logic [RW:0]    trial [QB][3];
  logic           ge    [QB][3];

  logic           rnd  [3];
  logic [QB:0]    q1   [3];
  logic [QB:0]    lim  [3];
  logic           sat  [3];
  logic [VW-1:0]  res  [3];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      for (int i = 0; i < 3; i++) begin
        trial[k][i] = {rem[k][i], low[k][i][QB-1]};
        ge[k][i]    = trial[k][i] >= {1'b0, nrm[k]};
      end
    end
    for (int i = 0; i < 3; i++) begin
      rnd[i] = {rem[QB][i], 1'b0} >= {1'b0, nrm[QB]};
      q1[i]  = {1'b0, quo[QB][i]} + (QB+1)'(rnd[i]);
      lim[i] = neg[QB][i] ? (QB+1)'(33'h080000000) : (QB+1)'(33'h07FFFFFFF);
      sat[i] = q1[i] > lim[i];
      if (sat[i]) begin
        res[i] = neg[QB][i] ? 32'h80000000 : 32'h7FFFFFFF;
      end else begin
        res[i] = neg[QB][i] ? -q1[i][VW-1:0] : q1[i][VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[QB-1:0], in_valid};
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm[0] <= in_item.n;
      neg[0] <= in_item.neg;
      deg[0] <= in_item.deg;
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= RW'(in_item.mag[i][MW-1:QB]);
        low[0][i] <= in_item.mag[i][QB-1:0];
        quo[0][i] <= '0;
      end
      for (int k = 0; k < QB; k++) begin
        nrm[k+1] <= nrm[k];
        neg[k+1] <= neg[k];
        deg[k+1] <= deg[k];
        for (int i = 0; i < 3; i++) begin
          rem[k+1][i] <= ge[k][i] ? RW'(trial[k][i] - {1'b0, nrm[k]}) : RW'(trial[k][i]);
          low[k+1][i] <= {low[k][i][QB-2:0], 1'b0};
          quo[k+1][i] <= {quo[k][i][QB-2:0], ge[k][i]};
        end
      end
      out_data <= {res[2], res[1], res[0]};
      out_deg  <= deg[QB];
      out_sat  <= sat[0] || sat[1] || sat[2];
    end
  end

endmodule
